>>> sv/mvcpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mvcpc_pkg;

  // Default sizes
  localparam int DEF_MAX_RING   = 32;
  localparam int DEF_VALUE_BITS = 32;
  localparam int DEF_INDEX_BITS = 20;

  // Fixed result field widths
  localparam int KIND_W = 3;
  localparam int MULT_W = 4;
  localparam int MULT_MAX = (1 << MULT_W) - 1;

  // Vertex classes
  typedef enum logic [KIND_W-1:0] {
    KIND_REGULAR = 3'd0,
    KIND_MINIMUM = 3'd1,
    KIND_MAXIMUM = 3'd2,
    KIND_SADDLE  = 3'd3,
    KIND_ODD     = 3'd4
  } point_kind_t;

endpackage

`default_nettype wire

>>> sv/mesh_vertex_critical_point_classifier_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Mesh vertex critical point classifier.
// Input stream (s_axis): one transfer per one-ring neighbor, in ring order.
//   tlast marks the final neighbor of a vertex. Each neighbor's sign is set
//   when it lies below the center (ties broken by vertex index) and sign
//   changes around the ring are counted.
// Output stream (m_axis): one transfer per vertex, issued after the transfer
//   that carries tlast, giving the vertex class, saddle multiplicity, the
//   change count and the count of neighbors equal to the center.
// The result is registered: it is valid in the cycle after the closing neighbor transfer.
// Throughput: one neighbor per cycle while s_axis_tready is high; the
//   per-neighbor compare and counter update sit between the input port and the result register.
// A waiting result blocks input only while the receiver stalls: s_axis_tready
//   stays high while the result register is empty or is being drained in the
//   same cycle. When the receiver stalls with a result held, input stops until
//   it is taken.
// Reset (rst, synchronous, active high): ring state clears to no neighbor
//   seen, the result register empties and s_axis_tready is held low.
module mesh_vertex_critical_point_classifier_top #(
  parameter int MAX_RING   = mvcpc_pkg::DEF_MAX_RING,
  parameter int VALUE_BITS = mvcpc_pkg::DEF_VALUE_BITS,
  parameter int INDEX_BITS = mvcpc_pkg::DEF_INDEX_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  // low bit up: vertex_id, center_value, neighbor_id, neighbor_value, zero fill
  input  wire logic [((2*INDEX_BITS+2*VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic s_axis_tvalid,
  input  wire logic s_axis_tlast,   // last_neighbor
  output logic      s_axis_tready,
  // low bit up: vertex_index, point_kind, saddle_multiplicity, sign_changes,
  // tie_count, zero fill
  output logic [((INDEX_BITS+mvcpc_pkg::KIND_W+mvcpc_pkg::MULT_W
                 +2*$clog2(MAX_RING+1)+7)/8)*8-1:0] m_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready
);
  import mvcpc_pkg::*;

  localparam int CNT_W = $clog2(MAX_RING + 1);
  localparam int OUT_W = INDEX_BITS + KIND_W + MULT_W + 2*CNT_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Input field unpacking
  logic [INDEX_BITS-1:0]        vertex_id;
  logic signed [VALUE_BITS-1:0] center_value;
  logic [INDEX_BITS-1:0]        neighbor_id;
  logic signed [VALUE_BITS-1:0] neighbor_value;

  assign vertex_id      = s_axis_tdata[INDEX_BITS-1:0];
  assign center_value   = s_axis_tdata[INDEX_BITS +: VALUE_BITS];
  assign neighbor_id    = s_axis_tdata[INDEX_BITS+VALUE_BITS +: INDEX_BITS];
  assign neighbor_value = s_axis_tdata[2*INDEX_BITS+VALUE_BITS +: VALUE_BITS];

  // Ring state
  logic             first_sign, first_sign_next;
  logic             previous_sign, previous_sign_next;
  logic [CNT_W-1:0] change_counter, change_counter_next;
  logic [CNT_W-1:0] tie_counter, tie_counter_next;
  logic             ring_started, ring_started_next;

  // Result register
  logic                  out_valid;
  logic [INDEX_BITS-1:0] out_vertex;
  point_kind_t           out_kind;
  logic [MULT_W-1:0]     out_mult;
  logic [CNT_W-1:0]      out_changes;
  logic [CNT_W-1:0]      out_ties;

  logic in_xfer;

  // Per-neighbor working values
  logic             is_tie;
  logic             sign;
  logic             ring_first;
  logic [CNT_W-1:0] changes_mid;
  logic [CNT_W-1:0] changes_closed;
  logic [CNT_W-2:0] half_changes;
  point_kind_t      kind;
  logic [MULT_W-1:0] mult;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    if (int'(c) < MAX_RING) begin
      sat_inc = c + 1'b1;
    end else begin
      sat_inc = CNT_W'(MAX_RING);
    end
  endfunction

  // Accept while the result slot is empty or draining
  assign s_axis_tready = !rst && (!out_valid || m_axis_tready);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Sign, counters and ring closing
  always_comb begin
    is_tie = (neighbor_value == center_value);
    if (is_tie) begin
      sign = (vertex_id > neighbor_id);
      tie_counter_next = sat_inc(tie_counter);
    end else begin
      sign = (neighbor_value < center_value);
      tie_counter_next = tie_counter;
    end

    if (!ring_started) begin
      ring_first  = sign;
      changes_mid = change_counter;
    end else begin
      ring_first  = first_sign;
      changes_mid = (sign != previous_sign) ? sat_inc(change_counter) : change_counter;
    end

    changes_closed = (sign != ring_first) ? sat_inc(changes_mid) : changes_mid;

    if (s_axis_tlast) begin
      first_sign_next     = 1'b0;
      previous_sign_next  = 1'b0;
      change_counter_next = '0;
      tie_counter_next    = '0;
      ring_started_next   = 1'b0;
    end else begin
      first_sign_next     = ring_first;
      previous_sign_next  = sign;
      change_counter_next = changes_mid;
      ring_started_next   = 1'b1;
    end
  end

  // Classification of the closed ring
  always_comb begin
    half_changes = changes_closed[CNT_W-1:1];
    mult = '0;
    if (changes_closed == '0) begin
      kind = ring_first ? KIND_MAXIMUM : KIND_MINIMUM;
    end else if (int'(changes_closed) == 2) begin
      kind = KIND_REGULAR;
    end else if (!changes_closed[0]) begin
      kind = KIND_SADDLE;
      if (int'(half_changes) - 1 > MULT_MAX) begin
        mult = MULT_W'(MULT_MAX);
      end else begin
        mult = MULT_W'(int'(half_changes) - 1);
      end
    end else begin
      kind = KIND_ODD;
    end
  end

  // Ring state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_sign     <= 1'b0;
      previous_sign  <= 1'b0;
      change_counter <= '0;
      tie_counter    <= '0;
      ring_started   <= 1'b0;
    end else if (in_xfer) begin
      first_sign     <= first_sign_next;
      previous_sign  <= previous_sign_next;
      change_counter <= change_counter_next;
      tie_counter    <= tie_counter_next;
      ring_started   <= ring_started_next;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && s_axis_tlast) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_xfer && s_axis_tlast) begin
      out_vertex  <= vertex_id;
      out_kind    <= kind;
      out_mult    <= mult;
      out_changes <= changes_closed;
      out_ties    <= is_tie ? sat_inc(tie_counter) : tie_counter;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_TDATA_W'({out_ties, out_changes, out_mult, out_kind, out_vertex});

endmodule

`default_nettype wire

>>> sv/mvcpc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mvcpc_checker #(
  parameter int MAX_RING   = mvcpc_pkg::DEF_MAX_RING,
  parameter int INDEX_BITS = mvcpc_pkg::DEF_INDEX_BITS
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tlast,
  input wire logic s_axis_tready,
  input wire logic [((INDEX_BITS+mvcpc_pkg::KIND_W+mvcpc_pkg::MULT_W
                     +2*$clog2(MAX_RING+1)+7)/8)*8-1:0] m_axis_tdata,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready
);
  import mvcpc_pkg::*;

  localparam int CNT_W = $clog2(MAX_RING + 1);

  logic [KIND_W-1:0] kind;
  logic [MULT_W-1:0] mult;
  logic [CNT_W-1:0]  changes;
  logic              in_xfer;

  assign kind    = m_axis_tdata[INDEX_BITS +: KIND_W];
  assign mult    = m_axis_tdata[INDEX_BITS+KIND_W +: MULT_W];
  assign changes = m_axis_tdata[INDEX_BITS+KIND_W+MULT_W +: CNT_W];
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // A stalled result holds its data
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A result only follows a closing neighbor transfer
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(in_xfer && s_axis_tlast))
    else $error("result without closing neighbor");

  // Extremes have no sign change, regular has two
  a_extreme: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (kind == KIND_MINIMUM || kind == KIND_MAXIMUM ||
                      kind == KIND_REGULAR)
    |-> mult == '0 && (changes == '0) == (kind != KIND_REGULAR) &&
        (kind != KIND_REGULAR || int'(changes) == 2))
    else $error("extreme or regular class disagrees with change count");

  // Saddles carry an even count of at least four and a nonzero multiplicity
  // only for them
  a_saddle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (mult != '0 || kind == KIND_SADDLE)
    |-> kind == KIND_SADDLE && !changes[0] && int'(changes) >= 4)
    else $error("saddle class disagrees with change count");

endmodule

bind mesh_vertex_critical_point_classifier_top mvcpc_checker #(
  .MAX_RING  (MAX_RING),
  .INDEX_BITS(INDEX_BITS)
) u_mvcpc_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tlast (s_axis_tlast),
  .s_axis_tready(s_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready)
);

`default_nettype wire
